// ===== rtl/abmg_pkg.sv =====
// Shared types, constants and helper functions of the adjacency bit matrix graph unit.
`default_nettype none

package abmg_pkg;

  // Graph geometry
  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = 6;   // vertex index bits
  localparam int ROW_W        = 64;  // one adjacency row
  localparam int CNT_W        = 7;   // vertex count / popcount bits
  localparam int EDGE_W       = 11;  // edge total bits

  localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

  // Request kinds
  typedef enum logic [2:0] {
    KIND_ADD_EDGE  = 3'd0,
    KIND_RM_EDGE   = 3'd1,
    KIND_RM_VERTEX = 3'd2,
    KIND_Q_EDGE    = 3'd3,
    KIND_DEGREE    = 3'd4,
    KIND_NEIGHBORS = 3'd5,
    KIND_DEG_RANGE = 3'd6
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_RANGE       = 2'd1,
    ST_SELF_LOOP   = 2'd2,
    ST_NOT_PRESENT = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // latch a new request
    logic rd_pair;  // read rows u and v
    logic eval;     // capture row data and flags
    logic wr_u;     // write modified row u
    logic wr_v;     // write modified row v
    logic sweep;    // walk the rows
    logic finish;   // update edge total, publish result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic do_write;    // edge add/remove changes the matrix
    logic do_sweep;    // row walk needed (vertex removal or degree range)
    logic sweep_done;  // all row reads issued
    logic pipe_busy;   // row walk pipeline still holds data
  } dp_sts_t;

  // Single set bit at a vertex position
  function automatic logic [ROW_W-1:0] vtx_bit(input logic [VTX_W-1:0] v);
    logic [ROW_W-1:0] m;
    m    = '0;
    m[v] = 1'b1;
    return m;
  endfunction

  // Adder tree popcount of one row
  function automatic logic [CNT_W-1:0] row_popcount(input logic [ROW_W-1:0] row);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, row[2*i]} + {1'b0, row[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/abmg_ctrl.sv =====
// Sequencing state machine of the adjacency bit matrix graph unit.
`default_nettype none

module abmg_ctrl
  import abmg_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_EVAL  = 8'b0000_0100,
    S_WR_U  = 8'b0000_1000,
    S_WR_V  = 8'b0001_0000,
    S_SWEEP = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_pair = 1'b1;
        state_d       = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.do_write) begin
          state_d = S_WR_U;
        end else if (sts_i.do_sweep) begin
          state_d = S_SWEEP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WR_U: begin
        cmd_o.wr_u = 1'b1;
        state_d    = S_WR_V;
      end
      S_WR_V: begin
        cmd_o.wr_v = 1'b1;
        state_d    = S_DONE;
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/abmg_dp.sv =====
// Datapath of the adjacency bit matrix graph unit: row memory, row walk, edge total, result.
`default_nettype none

module abmg_dp
  import abmg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CNT_W-1:0]  cfg_data_i,
  input  wire logic [2:0]        kind_i,
  input  wire logic [VTX_W-1:0]  vertex_u_i,
  input  wire logic [VTX_W-1:0]  vertex_v_i,
  input  wire dp_cmd_t           cmd_i,
  output dp_sts_t                sts_o,
  output logic                   result_valid_o,
  output logic [1:0]             status_o,
  output logic                   edge_present_o,
  output logic [VTX_W-1:0]       vertex_degree_o,
  output logic [CNT_W-1:0]       deg_low_o,
  output logic [VTX_W-1:0]       deg_high_o,
  output logic [EDGE_W-1:0]      edge_total_o,
  output logic [ROW_W-1:0]       neighbour_row_o
);

  // Configuration and request registers
  logic [CNT_W-1:0] active_q;
  logic [CNT_W-1:0] n_w;
  kind_e            kind_q;
  logic [VTX_W-1:0] u_q, v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CNT_W'(MAX_VERTICES);
    end else if (cfg_we_i) begin
      active_q <= cfg_data_i;
    end
  end

  // Vertex count in use, saturated to the matrix size
  assign n_w = (active_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : active_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_e'(kind_i);
      u_q    <= vertex_u_i;
      v_q    <= vertex_v_i;
    end
  end

  // Row memory with per-row valid bits (unwritten rows read as empty)
  logic [ROW_W-1:0]        mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic                    rd_en_a;
  logic [VTX_W-1:0]        rd_addr_a;
  logic [ROW_W-1:0]        rd_a_q, rd_b_q;
  logic                    rd_a_vld_q, rd_b_vld_q;
  logic [ROW_W-1:0]        row_a, row_b;
  logic                    we;
  logic [VTX_W-1:0]        waddr;
  logic [ROW_W-1:0]        wdata;

  // Row walk counters and pipeline
  logic [CNT_W-1:0] swp_cnt_q;
  logic [CNT_W-1:0] swp_end;
  logic             stats_mode;
  logic             issue;
  logic             s1_vld_q;
  logic [VTX_W-1:0] s1_idx_q;
  logic             s2_vld_q;
  logic             s2_nz_q;
  logic [CNT_W-1:0] s2_pop_q;
  logic [CNT_W-1:0] min_q;
  logic [CNT_W-1:0] max_q;

  assign stats_mode = (kind_q == KIND_DEG_RANGE);
  assign swp_end    = stats_mode ? n_w : CNT_W'(MAX_VERTICES);
  assign issue      = cmd_i.sweep && (swp_cnt_q < swp_end);
  assign rd_en_a    = cmd_i.rd_pair || issue;
  assign rd_addr_a  = cmd_i.rd_pair ? u_q : swp_cnt_q[VTX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_a) begin
      rd_a_q <= mem[rd_addr_a];
    end
    if (cmd_i.rd_pair) begin
      rd_b_q <= mem[v_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q  <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (we) begin
        row_vld_q[waddr] <= 1'b1;
      end
      if (rd_en_a) begin
        rd_a_vld_q <= row_vld_q[rd_addr_a];
      end
      if (cmd_i.rd_pair) begin
        rd_b_vld_q <= row_vld_q[v_q];
      end
    end
  end

  assign row_a = rd_a_vld_q ? rd_a_q : '0;
  assign row_b = rd_b_vld_q ? rd_b_q : '0;

  // Evaluation of the request against rows u and v
  logic             ev_in_range, ev_bit, ev_present;
  logic             in_range_q, bit_q, present_q;
  logic [ROW_W-1:0] row_u_q, row_v_q;
  logic [CNT_W-1:0] pop_q;

  assign ev_in_range = ({1'b0, u_q} < n_w) && ({1'b0, v_q} < n_w);
  assign ev_bit      = row_a[v_q];
  assign ev_present  = ({1'b0, v_q} < n_w) && (|row_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      in_range_q <= ev_in_range;
      bit_q      <= ev_bit;
      present_q  <= ev_present;
      row_u_q    <= row_a;
      row_v_q    <= row_b;
      pop_q      <= row_popcount(row_b);
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.do_write   = ((kind_q == KIND_ADD_EDGE) && ev_in_range && (u_q != v_q) && !ev_bit) ||
                       ((kind_q == KIND_RM_EDGE) && ev_in_range && ev_bit);
    sts_o.do_sweep   = ((kind_q == KIND_RM_VERTEX) && ev_present) ||
                       (kind_q == KIND_DEG_RANGE);
    sts_o.sweep_done = (swp_cnt_q >= swp_end);
    sts_o.pipe_busy  = s1_vld_q || s2_vld_q;
  end

  // Write port: edge set/clear on rows u and v, or row v and column v clear during a removal walk
  always_comb begin
    we    = 1'b0;
    waddr = u_q;
    wdata = '0;
    if (cmd_i.wr_u) begin
      we    = 1'b1;
      waddr = u_q;
      wdata = (kind_q == KIND_ADD_EDGE) ? (row_u_q | vtx_bit(v_q))
                                        : (row_u_q & ~vtx_bit(v_q));
    end else if (cmd_i.wr_v) begin
      we    = 1'b1;
      waddr = v_q;
      wdata = (kind_q == KIND_ADD_EDGE) ? (row_v_q | vtx_bit(u_q))
                                        : (row_v_q & ~vtx_bit(u_q));
    end else if (s1_vld_q && !stats_mode) begin
      we    = 1'b1;
      waddr = s1_idx_q;
      wdata = (s1_idx_q == v_q) ? '0 : (row_a & ~vtx_bit(v_q));
    end
  end

  // Row walk pipeline: read, then popcount, then min/max (degree range); read, then write back (vertex removal)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swp_cnt_q <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        swp_cnt_q <= '0;
      end else if (issue) begin
        swp_cnt_q <= swp_cnt_q + CNT_W'(1);
      end
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q && stats_mode;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_idx_q <= swp_cnt_q[VTX_W-1:0];
    end
    if (s1_vld_q) begin
      s2_nz_q  <= |row_a;
      s2_pop_q <= row_popcount(row_a);
    end
    if (cmd_i.load) begin
      min_q <= n_w;
      max_q <= '0;
    end else if (s2_vld_q && s2_nz_q) begin
      if (s2_pop_q < min_q) min_q <= s2_pop_q;
      if (s2_pop_q > max_q) max_q <= s2_pop_q;
    end
  end

  // Edge total update at the end of a request
  logic [EDGE_W-1:0] cnt_q, cnt_d;
  logic [EDGE_W-1:0] pop_ext;

  assign pop_ext = EDGE_W'(pop_q);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.finish) begin
      if ((kind_q == KIND_ADD_EDGE) && in_range_q && (u_q != v_q) && !bit_q) begin
        if (cnt_q != EDGE_MAX) cnt_d = cnt_q + EDGE_W'(1);
      end else if ((kind_q == KIND_RM_EDGE) && in_range_q && bit_q) begin
        if (cnt_q != '0) cnt_d = cnt_q - EDGE_W'(1);
      end else if ((kind_q == KIND_RM_VERTEX) && present_q) begin
        cnt_d = (cnt_q > pop_ext) ? (cnt_q - pop_ext) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      cnt_q          <= cnt_d;
      result_valid_o <= cmd_i.finish;
    end
  end

  // Result fields per request kind
  status_e          res_status;
  logic             res_present;
  logic [VTX_W-1:0] res_degree;
  logic [CNT_W-1:0] res_min;
  logic [VTX_W-1:0] res_max;
  logic [ROW_W-1:0] res_row;

  always_comb begin
    res_status  = ST_OK;
    res_present = 1'b0;
    res_degree  = '0;
    res_min     = '0;
    res_max     = '0;
    res_row     = '0;
    unique case (kind_q)
      KIND_ADD_EDGE: begin
        if (!in_range_q)       res_status = ST_RANGE;
        else if (u_q == v_q)   res_status = ST_SELF_LOOP;
      end
      KIND_RM_EDGE: begin
        if (!in_range_q)       res_status = ST_RANGE;
      end
      KIND_Q_EDGE: begin
        res_present = in_range_q && bit_q;
      end
      KIND_DEGREE: begin
        if (present_q) res_degree = pop_q[VTX_W-1:0];
        else           res_status = ST_NOT_PRESENT;
      end
      KIND_NEIGHBORS: begin
        if (present_q) res_row    = row_v_q;
        else           res_status = ST_NOT_PRESENT;
      end
      KIND_DEG_RANGE: begin
        res_min = min_q;
        res_max = max_q[VTX_W-1:0];
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_o        <= res_status;
      edge_present_o  <= res_present;
      vertex_degree_o <= res_degree;
      deg_low_o       <= res_min;
      deg_high_o      <= res_max;
      edge_total_o    <= cnt_d;
      neighbour_row_o <= res_row;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/adjacency_bit_matrix_graph_unit.sv =====
// Top level of the adjacency bit matrix graph unit: controller, datapath and checks.
//
//   channel   handshake            payload
//   request   start / busy         kind_i, vertex_u_i, vertex_v_i
//   result    result_valid_o       status_o, edge_present_o, vertex_degree_o,
//                                  deg_low_o, deg_high_o, edge_total_o,
//                                  neighbour_row_o
//   config    cfg_we_i             cfg_data_i (active vertex count)
//
// A request is taken when start is high and busy is low; its result shows for one cycle on
// result_valid_o. Removal of a present vertex walks all 64 rows, one per cycle; degree range
// walks only the rows of the vertex count in use.
// Reset clears the matrix at once through per-row valid bits; no clearing pass.
// The receiver cannot stall; a new request may start in the cycle the result is shown.
`default_nettype none

module adjacency_bit_matrix_graph_unit
  import abmg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CNT_W-1:0]  cfg_data_i,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        kind_i,
  input  wire logic [VTX_W-1:0]  vertex_u_i,
  input  wire logic [VTX_W-1:0]  vertex_v_i,
  output logic                   result_valid_o,
  output logic [1:0]             status_o,
  output logic                   edge_present_o,
  output logic [VTX_W-1:0]       vertex_degree_o,
  output logic [CNT_W-1:0]       deg_low_o,
  output logic [VTX_W-1:0]       deg_high_o,
  output logic [EDGE_W-1:0]      edge_total_o,
  output logic [ROW_W-1:0]       neighbour_row_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  abmg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  abmg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .vertex_u_i      (vertex_u_i),
    .vertex_v_i      (vertex_v_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .edge_present_o  (edge_present_o),
    .vertex_degree_o (vertex_degree_o),
    .deg_low_o       (deg_low_o),
    .deg_high_o      (deg_high_o),
    .edge_total_o    (edge_total_o),
    .neighbour_row_o (neighbour_row_o)
  );

  // An accepted request makes the unit busy on the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // A result only follows a cycle of work on a request
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a request in progress");

  // One result per request: strobes never come back to back
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe repeated");

endmodule

`default_nettype wire

// ===== verif/abmg_graph_checker.sv =====
// Checker for the adjacency bit matrix graph unit: tracks the graph and compares each result.
module abmg_graph_checker
  import abmg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CNT_W-1:0]  cfg_data_i,
  input  wire logic              start_i,
  input  wire logic              busy_i,
  input  wire logic [2:0]        kind_i,
  input  wire logic [VTX_W-1:0]  vertex_u_i,
  input  wire logic [VTX_W-1:0]  vertex_v_i,
  input  wire logic              result_valid_i,
  input  wire logic [1:0]        status_i,
  input  wire logic              edge_present_i,
  input  wire logic [VTX_W-1:0]  vertex_degree_i,
  input  wire logic [CNT_W-1:0]  deg_low_i,
  input  wire logic [VTX_W-1:0]  deg_high_i,
  input  wire logic [EDGE_W-1:0] edge_total_i,
  input  wire logic [ROW_W-1:0]  neighbour_row_i,
  output int unsigned            error_count_o,
  output int unsigned            pending_o,
  output int unsigned            results_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e               status;
    logic                  edge_present;
    logic [VTX_W-1:0]      degree;
    logic [CNT_W-1:0]      min_deg;
    logic [VTX_W-1:0]      max_deg;
    logic [EDGE_W-1:0]     edges;
    logic [ROW_W-1:0]      row;
  } graph_result_t;

  // Shadow copy of the graph and the vertex count register
  logic [ROW_W-1:0]  adj_rows [MAX_VERTICES];
  logic [EDGE_W-1:0] edge_total;
  logic [CNT_W-1:0]  vertex_limit;

  graph_result_t expected_results [$];
  int unsigned   mismatches;
  int unsigned   checked;

  function automatic int unsigned ones_in_row(input logic [ROW_W-1:0] row);
    int unsigned c;
    c = 0;
    for (int i = 0; i < ROW_W; i++) c += row[i];
    return c;
  endfunction

  // Apply one request to the shadow graph and work out its result
  task automatic predict_graph_step(input logic [2:0] kind, input logic [VTX_W-1:0] u,
                                    input logic [VTX_W-1:0] v, output graph_result_t res);
    int unsigned n;
    int unsigned d;
    int unsigned lo;
    int unsigned hi;
    logic        in_range;
    logic        v_present;
    n         = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
    in_range  = (u < n) && (v < n);
    v_present = (v < n) && (adj_rows[v] != '0);
    res       = '0;
    res.status = ST_OK;
    case (kind)
      KIND_ADD_EDGE: begin
        if (!in_range) res.status = ST_RANGE;
        else if (u == v) res.status = ST_SELF_LOOP;
        else if (!adj_rows[u][v]) begin
          adj_rows[u][v] = 1'b1;
          adj_rows[v][u] = 1'b1;
          if (edge_total != EDGE_MAX) edge_total++;
        end
      end
      KIND_RM_EDGE: begin
        if (!in_range) res.status = ST_RANGE;
        else if (adj_rows[u][v]) begin
          adj_rows[u][v] = 1'b0;
          adj_rows[v][u] = 1'b0;
          if (edge_total != '0) edge_total--;
        end
      end
      KIND_RM_VERTEX: begin
        // clears row and column; absent or out-of-range vertex is a no-op
        if (v_present) begin
          d = ones_in_row(adj_rows[v]);
          edge_total = (edge_total > d) ? EDGE_W'(edge_total - d) : '0;
          adj_rows[v] = '0;
          for (int i = 0; i < MAX_VERTICES; i++) adj_rows[i][v] = 1'b0;
        end
      end
      KIND_Q_EDGE: begin
        if (in_range) res.edge_present = adj_rows[u][v];
      end
      KIND_DEGREE: begin
        if (v_present) res.degree = VTX_W'(ones_in_row(adj_rows[v]));
        else res.status = ST_NOT_PRESENT;
      end
      KIND_NEIGHBORS: begin
        if (v_present) res.row = adj_rows[v];
        else res.status = ST_NOT_PRESENT;
      end
      KIND_DEG_RANGE: begin
        // only vertices with a neighbor count; none gives min = n, max = 0
        lo = n;
        hi = 0;
        for (int i = 0; i < n; i++) begin
          if (adj_rows[i] != '0) begin
            d = ones_in_row(adj_rows[i]);
            if (d < lo) lo = d;
            if (d > hi) hi = d;
          end
        end
        res.min_deg = CNT_W'(lo);
        res.max_deg = VTX_W'(hi);
      end
      default: ;
    endcase
    res.edges = edge_total;
  endtask

  task automatic check_field(input string name, input logic [ROW_W-1:0] exp_val,
                             input logic [ROW_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Compare one shown result against the oldest outstanding request
  task automatic check_result();
    graph_result_t exp_res;
    if (expected_results.size() == 0) begin
      $display("%0t: result shown with no request outstanding", $time);
      mismatches++;
    end else begin
      exp_res = expected_results.pop_front();
      check_field("status", ROW_W'(exp_res.status), ROW_W'(status_i));
      check_field("edge_present", ROW_W'(exp_res.edge_present), ROW_W'(edge_present_i));
      check_field("vertex_degree", ROW_W'(exp_res.degree), ROW_W'(vertex_degree_i));
      check_field("deg_low", ROW_W'(exp_res.min_deg), ROW_W'(deg_low_i));
      check_field("deg_high", ROW_W'(exp_res.max_deg), ROW_W'(deg_high_i));
      check_field("edge_total", ROW_W'(exp_res.edges), ROW_W'(edge_total_i));
      check_field("neighbour_row", exp_res.row, neighbour_row_i);
      checked++;
    end
  endtask

  // Results are compared before a new request is queued at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    graph_result_t res;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_VERTICES; i++) adj_rows[i] = '0;
      edge_total   = '0;
      vertex_limit = 7'd64;
      expected_results.delete();
      mismatches   = 0;
      checked      = 0;
      error_count_o     <= 0;
      pending_o         <= 0;
      results_checked_o <= 0;
    end else begin
      if (result_valid_i) check_result();
      if (cfg_we_i) vertex_limit = cfg_data_i;
      if (start_i && !busy_i) begin
        predict_graph_step(kind_i, vertex_u_i, vertex_v_i, res);
        expected_results.push_back(res);
      end
      error_count_o     <= mismatches;
      pending_o         <= expected_results.size();
      results_checked_o <= checked;
    end
  end

endmodule

// ===== verif/tb_adjacency_bit_matrix_graph_unit.sv =====
// Testbench top for the adjacency bit matrix graph unit: stimulus, watchdog and verdict.
module tb_adjacency_bit_matrix_graph_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import abmg_pkg::*;

  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int IDLE_LIMIT  = 3000;  // cycles without any request, result or config write
  localparam int TAIL_CYCLES = 100;
  localparam int PHASES      = 13;

  logic              clk;
  logic              rst_n    = 1'b0;
  logic              cfg_we   = 1'b0;
  logic [CNT_W-1:0]  cfg_data = '0;
  logic              start    = 1'b0;
  logic [2:0]        kind     = '0;
  logic [VTX_W-1:0]  vtx_u    = '0;
  logic [VTX_W-1:0]  vtx_v    = '0;
  logic              busy;
  logic              result_valid;
  logic [1:0]        status;
  logic              edge_present;
  logic [VTX_W-1:0]  vertex_degree;
  logic [CNT_W-1:0]  deg_low;
  logic [VTX_W-1:0]  deg_high;
  logic [EDGE_W-1:0] edge_total;
  logic [ROW_W-1:0]  neighbour_row;

  int unsigned error_count;
  int unsigned pending;
  int unsigned results_checked;

  int unsigned kind_hits [8];
  int unsigned settings_used;
  int unsigned verts_in_use;
  int unsigned idle_cycles;

  // Vertex count per random phase, and requests per phase
  int unsigned phase_limit [PHASES] = '{8, 64, 2, 16, 1, 127, 5, 32, 0, 100, 12, 6, 64};
  int unsigned phase_items [PHASES] = '{300, 250, 80, 250, 40, 150, 200, 250, 30, 100,
                                        200, 100, 50};

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  adjacency_bit_matrix_graph_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind),
    .vertex_u_i      (vtx_u),
    .vertex_v_i      (vtx_v),
    .result_valid_o  (result_valid),
    .status_o        (status),
    .edge_present_o  (edge_present),
    .vertex_degree_o (vertex_degree),
    .deg_low_o       (deg_low),
    .deg_high_o      (deg_high),
    .edge_total_o    (edge_total),
    .neighbour_row_o (neighbour_row)
  );

  abmg_graph_checker graph_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_data_i        (cfg_data),
    .start_i           (start),
    .busy_i            (busy),
    .kind_i            (kind),
    .vertex_u_i        (vtx_u),
    .vertex_v_i        (vtx_v),
    .result_valid_i    (result_valid),
    .status_i          (status),
    .edge_present_i    (edge_present),
    .vertex_degree_i   (vertex_degree),
    .deg_low_i         (deg_low),
    .deg_high_i        (deg_high),
    .edge_total_i      (edge_total),
    .neighbour_row_i   (neighbour_row),
    .error_count_o     (error_count),
    .pending_o         (pending),
    .results_checked_o (results_checked)
  );

  // Watchdog: ends the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || result_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request and hold it until the unit takes it
  task automatic issue_request(input logic [2:0] k, input logic [VTX_W-1:0] u,
                               input logic [VTX_W-1:0] v);
    start <= 1'b1;
    kind  <= k;
    vtx_u <= u;
    vtx_v <= v;
    do @(posedge clk); while (busy);
    kind_hits[k]++;
  endtask

  // Stop sending until every outstanding request has its result
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic set_vertex_count(input logic [CNT_W-1:0] val);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    verts_in_use = (val > MAX_VERTICES) ? MAX_VERTICES : val;
    settings_used++;
  endtask

  // Occasional sender gap; mostly short, sometimes long enough to span a row walk
  task automatic maybe_idle(input bit allow);
    int unsigned gap;
    if (allow && $urandom_range(0, 99) < 10) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly in-range vertices so the graph fills up; a few anywhere
  function automatic logic [VTX_W-1:0] pick_vertex(input int unsigned n);
    if (n == 0 || $urandom_range(0, 9) == 0) return VTX_W'($urandom_range(0, 63));
    return VTX_W'($urandom_range(0, n - 1));
  endfunction

  task automatic random_request(input int unsigned n);
    int unsigned roll;
    logic [2:0]  k;
    roll = $urandom_range(0, 99);
    if (roll < 35)      k = KIND_ADD_EDGE;
    else if (roll < 47) k = KIND_RM_EDGE;
    else if (roll < 54) k = KIND_RM_VERTEX;
    else if (roll < 66) k = KIND_Q_EDGE;
    else if (roll < 76) k = KIND_DEGREE;
    else if (roll < 86) k = KIND_NEIGHBORS;
    else if (roll < 98) k = KIND_DEG_RANGE;
    else                k = KIND_UNUSED;
    issue_request(k, pick_vertex(n), pick_vertex(n));
  endtask

  initial begin
    int unsigned item_no;
    int unsigned total;
    foreach (kind_hits[i]) kind_hits[i] = 0;
    settings_used = 0;
    verts_in_use  = MAX_VERTICES;
    item_no       = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full vertex range
    set_vertex_count(7'd64);
    issue_request(KIND_DEG_RANGE, 6'd0, 6'd0);    // empty graph
    issue_request(KIND_ADD_EDGE, 6'd0, 6'd63);
    issue_request(KIND_ADD_EDGE, 6'd63, 6'd0);    // already there
    issue_request(KIND_ADD_EDGE, 6'd5, 6'd5);     // self-loop
    issue_request(KIND_Q_EDGE, 6'd63, 6'd0);
    issue_request(KIND_Q_EDGE, 6'd1, 6'd2);
    issue_request(KIND_DEGREE, 6'd0, 6'd0);
    issue_request(KIND_NEIGHBORS, 6'd0, 6'd63);
    issue_request(KIND_DEGREE, 6'd0, 6'd10);      // no neighbors yet
    issue_request(KIND_NEIGHBORS, 6'd0, 6'd10);
    issue_request(KIND_ADD_EDGE, 6'd0, 6'd10);
    issue_request(KIND_ADD_EDGE, 6'd10, 6'd63);
    issue_request(KIND_DEG_RANGE, 6'd0, 6'd0);
    issue_request(KIND_RM_EDGE, 6'd1, 6'd2);      // missing edge
    issue_request(KIND_RM_EDGE, 6'd7, 6'd7);      // same endpoints
    issue_request(KIND_RM_VERTEX, 6'd0, 6'd0);
    issue_request(KIND_RM_VERTEX, 6'd0, 6'd0);    // now absent
    issue_request(KIND_UNUSED, 6'd63, 6'd63);

    // Directed: shrunk range, high rows keep their edges
    set_vertex_count(7'd4);
    issue_request(KIND_ADD_EDGE, 6'd5, 6'd5);     // range beats self-loop
    issue_request(KIND_RM_EDGE, 6'd63, 6'd10);
    issue_request(KIND_Q_EDGE, 6'd10, 6'd63);
    issue_request(KIND_DEGREE, 6'd0, 6'd63);
    issue_request(KIND_RM_VERTEX, 6'd0, 6'd63);
    issue_request(KIND_DEG_RANGE, 6'd0, 6'd0);

    // Directed: zero vertices in use
    set_vertex_count(7'd0);
    issue_request(KIND_ADD_EDGE, 6'd0, 6'd0);
    issue_request(KIND_DEG_RANGE, 6'd0, 6'd0);

    // Random phases, each with its own vertex count; one long stretch without gaps
    for (int p = 0; p < PHASES; p++) begin
      set_vertex_count(CNT_W'(phase_limit[p]));
      for (int i = 0; i < phase_items[p]; i++) begin
        random_request(verts_in_use);
        maybe_idle(!(item_no >= 600 && item_no < 900));
        item_no++;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    total = 0;
    foreach (kind_hits[i]) total += kind_hits[i];
    $display("Covered %0d requests: add %0d, remove edge %0d, remove vertex %0d, query %0d,",
             total, kind_hits[KIND_ADD_EDGE], kind_hits[KIND_RM_EDGE],
             kind_hits[KIND_RM_VERTEX], kind_hits[KIND_Q_EDGE]);
    $display("degree %0d, neighbors %0d, range %0d, unused %0d; %0d vertex counts, %0d results",
             kind_hits[KIND_DEGREE], kind_hits[KIND_NEIGHBORS], kind_hits[KIND_DEG_RANGE],
             kind_hits[KIND_UNUSED], settings_used, results_checked);
    if (error_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/abmg_pkg.sv
rtl/abmg_ctrl.sv
rtl/abmg_dp.sv
rtl/adjacency_bit_matrix_graph_unit.sv
verif/abmg_graph_checker.sv
verif/tb_adjacency_bit_matrix_graph_unit.sv
